// ----- design/flvpk_pkg.sv -----
// shared types and constants of the flv avc video tag packetizer
package flvpk_pkg;

  localparam logic [4:0] NAL_TYPE_MASK = 5'h1f;
  localparam logic [4:0] NAL_IDR       = 5'd5;
  localparam logic [4:0] NAL_SPS       = 5'd7;
  localparam logic [4:0] NAL_PPS       = 5'd8;

  localparam logic [7:0] FLAGS_KEY     = 8'h17;
  localparam logic [7:0] FLAGS_INTER   = 8'h27;
  localparam logic [7:0] PKT_NALU      = 8'h01;
  localparam logic [7:0] CFG_VERSION   = 8'h01;
  localparam logic [7:0] CFG_LEN_SIZE  = 8'hff;
  localparam logic [7:0] CFG_NUM_SPS   = 8'he1;
  localparam logic [7:0] CFG_NUM_PPS   = 8'h01;

  localparam logic [2:0] POS_TYPE      = 3'd4;
  localparam logic [2:0] POS_BODY      = 3'd5;
  localparam logic [3:0] HDR_LAST      = 4'd9;

  typedef enum logic [3:0] {
    ST_IN  = 4'b0001,
    ST_HDR = 4'b0010,
    ST_RD  = 4'b0100,
    ST_WR  = 4'b1000
  } state_t;

  typedef enum logic [3:0] {
    SEC_HEAD = 4'b0001,
    SEC_SPS  = 4'b0010,
    SEC_MID  = 4'b0100,
    SEC_PPS  = 4'b1000
  } sec_t;

endpackage

// ----- design/flv_avc_video_tag_packetizer.sv -----
// top level of the flv avc video tag packetizer
//
//  channel  | dir | handshake             | payload
//  in_      | in  | in_tvalid/in_tready   | tdata {dts_in, pts_in, in_byte}, tlast in_last
//  out_     | out | out_tvalid/out_tready | tdata {tag_dts, out_byte}, tlast, tuser keyframe
//  cfg_     | in  | cfg_valid/cfg_ready   | cfg_data cts_offset
//
// unit bytes stream at one beat per cycle through the output register while it is not stalled
// nal type byte opens a 10 beat header, one beat per cycle if not stalled, input held
// the config record reads the sps/pps memories, each beat through a read state, then a load state
// reset is synchronous, active low, and clears all control state
// output stalls hold the input, since input acceptance needs a free output register
module flv_avc_video_tag_packetizer #(
  parameter int SPS_MAX = 32,
  parameter int PPS_MAX = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // in_byte[7:0], pts_in[39:8], dts_in[71:40]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // out_byte[7:0], tag_dts[39:8]
  output logic        out_tlast,
  output logic        out_tuser,  // tag_keyframe[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data
);

  localparam int MAXP = (SPS_MAX > PPS_MAX) ? SPS_MAX : PPS_MAX;
  localparam int SAW  = $clog2(SPS_MAX);
  localparam int PAW  = (PPS_MAX > 1) ? $clog2(PPS_MAX) : 1;
  localparam int SLW  = $clog2(SPS_MAX + 1);
  localparam int PLW  = $clog2(PPS_MAX + 1);
  localparam int CW   = $clog2(MAXP + 2);
  localparam int RCW  = $clog2(MAXP + 16);
  localparam logic [CW-1:0] SPS_LIM = CW'(SPS_MAX);
  localparam logic [CW-1:0] PPS_LIM = CW'(PPS_MAX);

  flvpk_pkg::state_t state_r, state_nxt;
  flvpk_pkg::sec_t   sec_r, sec_nxt;

  logic [2:0]     pos_r, pos_nxt;
  logic [4:0]     ptype_r, ptype_nxt;
  logic [23:0]    held_cts_r, held_cts_nxt;
  logic [31:0]    held_dts_r, held_dts_nxt;
  logic [7:0]     prefix_r [4];
  logic [7:0]     hbyte_r, hbyte_nxt;
  logic           hlast_r, hlast_nxt;
  logic           kf_r, kf_nxt;
  logic [3:0]     hidx_r, hidx_nxt;
  logic [SLW-1:0] sps_len_r, sps_len_nxt;
  logic [PLW-1:0] pps_len_r, pps_len_nxt;
  logic [CW-1:0]  cap_cnt_r, cap_cnt_nxt;
  logic           cap_act_r, cap_act_nxt;
  logic           sent_r, sent_nxt;
  logic [23:0]    cts_off_r;
  logic [RCW-1:0] rcnt_r, rcnt_nxt;

  logic           out_valid_r, out_valid_nxt;
  logic [7:0]     out_byte_r, out_byte_nxt;
  logic           out_last_r, out_last_nxt;
  logic [31:0]    out_dts_r, out_dts_nxt;
  logic           out_kf_r, out_kf_nxt;

  logic [7:0]     sps_mem [SPS_MAX];
  logic [7:0]     pps_mem [PPS_MAX];
  logic [7:0]     sps_rd_r, pps_rd_r;
  logic [SAW-1:0] sps_raddr;
  logic [PAW-1:0] pps_raddr;
  logic           sps_we, pps_we, pre_we;

  logic           acc_in, out_free;
  logic [7:0]     in_b;
  logic [31:0]    in_pts, in_dts, dts_sel;
  logic [4:0]     utype;
  logic           is_cfg, is_sps, act, cap_we, len_ok;
  logic [CW-1:0]  lim, cnt_in, cnt_cap;
  logic [7:0]     hdr_byte, rec_byte;
  logic           rec_last;
  logic [RCW-1:0] sps_k;

  assign in_b   = in_tdata[7:0];
  assign in_pts = in_tdata[39:8];
  assign in_dts = in_tdata[71:40];

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == flvpk_pkg::ST_IN) && out_free;
  assign acc_in    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_dts_r, out_byte_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_kf_r;

  assign dts_sel = ((in_dts != 32'd0) && !in_dts[31]) ? in_dts : in_pts;

  // parameter set capture
  assign utype   = (pos_r == flvpk_pkg::POS_TYPE) ? (in_b[4:0] & flvpk_pkg::NAL_TYPE_MASK)
                                                  : ptype_r;
  assign is_sps  = utype == flvpk_pkg::NAL_SPS;
  assign is_cfg  = is_sps || (utype == flvpk_pkg::NAL_PPS);
  assign lim     = is_sps ? SPS_LIM : PPS_LIM;
  assign act     = (pos_r == flvpk_pkg::POS_TYPE)
                   ? (is_sps ? (sps_len_r == '0) : (pps_len_r == '0)) : cap_act_r;
  assign cnt_in  = (pos_r == flvpk_pkg::POS_TYPE) ? '0 : cap_cnt_r;
  assign cap_we  = act && (cnt_in < lim);
  assign cnt_cap = act ? (cap_we ? cnt_in + CW'(1) : lim + CW'(1)) : cnt_in;
  assign len_ok  = act && (cnt_cap != '0) && (cnt_cap <= lim);
  assign pre_we  = acc_in && (pos_r < flvpk_pkg::POS_TYPE);

  // header burst
  always_comb begin
    unique case (hidx_r)
      4'd0:    hdr_byte = kf_r ? flvpk_pkg::FLAGS_KEY : flvpk_pkg::FLAGS_INTER;
      4'd1:    hdr_byte = flvpk_pkg::PKT_NALU;
      4'd2:    hdr_byte = held_cts_r[23:16];
      4'd3:    hdr_byte = held_cts_r[15:8];
      4'd4:    hdr_byte = held_cts_r[7:0];
      4'd5:    hdr_byte = prefix_r[0];
      4'd6:    hdr_byte = prefix_r[1];
      4'd7:    hdr_byte = prefix_r[2];
      4'd8:    hdr_byte = prefix_r[3];
      4'd9:    hdr_byte = hbyte_r;
      default: hdr_byte = 8'h00;
    endcase
  end

  // configuration record
  assign sps_k     = rcnt_r - RCW'(5);
  assign sps_raddr = (sec_r == flvpk_pkg::SEC_HEAD) ? sps_k[SAW-1:0] : rcnt_r[SAW-1:0];
  assign pps_raddr = rcnt_r[PAW-1:0];
  assign rec_last  = (sec_r == flvpk_pkg::SEC_PPS) && (rcnt_r + RCW'(1) == RCW'(pps_len_r));

  always_comb begin
    rec_byte = 8'h00;
    unique case (sec_r)
      flvpk_pkg::SEC_HEAD: begin
        unique case (rcnt_r)
          RCW'(0):  rec_byte = flvpk_pkg::FLAGS_KEY;
          RCW'(5):  rec_byte = flvpk_pkg::CFG_VERSION;
          RCW'(6), RCW'(7), RCW'(8):
            rec_byte = (sps_k < RCW'(sps_len_r)) ? sps_rd_r : 8'h00;
          RCW'(9):  rec_byte = flvpk_pkg::CFG_LEN_SIZE;
          RCW'(10): rec_byte = flvpk_pkg::CFG_NUM_SPS;
          RCW'(12): rec_byte = 8'(sps_len_r);
          default:  rec_byte = 8'h00;
        endcase
      end
      flvpk_pkg::SEC_SPS: rec_byte = sps_rd_r;
      flvpk_pkg::SEC_MID: begin
        unique case (rcnt_r)
          RCW'(0):  rec_byte = flvpk_pkg::CFG_NUM_PPS;
          RCW'(2):  rec_byte = 8'(pps_len_r);
          default:  rec_byte = 8'h00;
        endcase
      end
      flvpk_pkg::SEC_PPS: rec_byte = pps_rd_r;
      default: rec_byte = 8'h00;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    sec_nxt       = sec_r;
    pos_nxt       = pos_r;
    ptype_nxt     = ptype_r;
    held_cts_nxt  = held_cts_r;
    held_dts_nxt  = held_dts_r;
    hbyte_nxt     = hbyte_r;
    hlast_nxt     = hlast_r;
    kf_nxt        = kf_r;
    hidx_nxt      = hidx_r;
    sps_len_nxt   = sps_len_r;
    pps_len_nxt   = pps_len_r;
    cap_cnt_nxt   = cap_cnt_r;
    cap_act_nxt   = cap_act_r;
    sent_nxt      = sent_r;
    rcnt_nxt      = rcnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_dts_nxt   = out_dts_r;
    out_kf_nxt    = out_kf_r;
    sps_we        = 1'b0;
    pps_we        = 1'b0;

    unique case (state_r)
      flvpk_pkg::ST_IN: begin
        if (acc_in) begin
          if (pos_r == 3'd0) begin
            held_dts_nxt = dts_sel;
            held_cts_nxt = in_pts[23:0] + cts_off_r - dts_sel[23:0];
          end
          if (pos_r < flvpk_pkg::POS_TYPE) begin
            pos_nxt = in_tlast ? 3'd0 : pos_r + 3'd1;
          end else begin
            pos_nxt = in_tlast ? 3'd0 : flvpk_pkg::POS_BODY;
            if (pos_r == flvpk_pkg::POS_TYPE) begin
              ptype_nxt = utype;
              kf_nxt    = utype == flvpk_pkg::NAL_IDR;
            end
            if (is_cfg) begin
              cap_act_nxt = act;
              cap_cnt_nxt = cnt_cap;
              sps_we      = cap_we && is_sps;
              pps_we      = cap_we && !is_sps;
              if (in_tlast) begin
                cap_act_nxt = 1'b0;
                if (len_ok && is_sps) sps_len_nxt = cnt_cap[SLW-1:0];
                if (len_ok && !is_sps) pps_len_nxt = cnt_cap[PLW-1:0];
                if ((sps_len_nxt != '0) && (pps_len_nxt != '0) && !sent_r) begin
                  sent_nxt  = 1'b1;
                  state_nxt = flvpk_pkg::ST_RD;
                  sec_nxt   = flvpk_pkg::SEC_HEAD;
                  rcnt_nxt  = '0;
                end
              end
            end else if (pos_r == flvpk_pkg::POS_TYPE) begin
              hbyte_nxt = in_b;
              hlast_nxt = in_tlast;
              hidx_nxt  = 4'd0;
              state_nxt = flvpk_pkg::ST_HDR;
            end else begin
              out_valid_nxt = 1'b1;
              out_byte_nxt  = in_b;
              out_last_nxt  = in_tlast;
              out_dts_nxt   = held_dts_r;
              out_kf_nxt    = kf_r;
            end
          end
        end
      end
      flvpk_pkg::ST_HDR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = hdr_byte;
          out_last_nxt  = hlast_r && (hidx_r == flvpk_pkg::HDR_LAST);
          out_dts_nxt   = held_dts_r;
          out_kf_nxt    = kf_r;
          hidx_nxt      = hidx_r + 4'd1;
          if (hidx_r == flvpk_pkg::HDR_LAST) state_nxt = flvpk_pkg::ST_IN;
        end
      end
      flvpk_pkg::ST_RD: begin
        state_nxt = flvpk_pkg::ST_WR;
      end
      flvpk_pkg::ST_WR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = rec_byte;
          out_last_nxt  = rec_last;
          out_dts_nxt   = held_dts_r;
          out_kf_nxt    = 1'b0;
          state_nxt     = rec_last ? flvpk_pkg::ST_IN : flvpk_pkg::ST_RD;
          rcnt_nxt      = rcnt_r + RCW'(1);
          unique case (sec_r)
            flvpk_pkg::SEC_HEAD: begin
              if (rcnt_r == RCW'(12)) begin
                sec_nxt  = flvpk_pkg::SEC_SPS;
                rcnt_nxt = '0;
              end
            end
            flvpk_pkg::SEC_SPS: begin
              if (rcnt_r + RCW'(1) == RCW'(sps_len_r)) begin
                sec_nxt  = flvpk_pkg::SEC_MID;
                rcnt_nxt = '0;
              end
            end
            flvpk_pkg::SEC_MID: begin
              if (rcnt_r == RCW'(2)) begin
                sec_nxt  = flvpk_pkg::SEC_PPS;
                rcnt_nxt = '0;
              end
            end
            flvpk_pkg::SEC_PPS: ;
            default: ;
          endcase
        end
      end
      default: state_nxt = flvpk_pkg::ST_IN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= flvpk_pkg::ST_IN;
      sec_r       <= flvpk_pkg::SEC_HEAD;
      pos_r       <= 3'd0;
      ptype_r     <= 5'd0;
      held_cts_r  <= 24'd0;
      held_dts_r  <= 32'd0;
      hidx_r      <= 4'd0;
      sps_len_r   <= '0;
      pps_len_r   <= '0;
      cap_cnt_r   <= '0;
      cap_act_r   <= 1'b0;
      sent_r      <= 1'b0;
      cts_off_r   <= 24'd0;
      rcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sec_r       <= sec_nxt;
      pos_r       <= pos_nxt;
      ptype_r     <= ptype_nxt;
      held_cts_r  <= held_cts_nxt;
      held_dts_r  <= held_dts_nxt;
      hidx_r      <= hidx_nxt;
      sps_len_r   <= sps_len_nxt;
      pps_len_r   <= pps_len_nxt;
      cap_cnt_r   <= cap_cnt_nxt;
      cap_act_r   <= cap_act_nxt;
      sent_r      <= sent_nxt;
      rcnt_r      <= rcnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) cts_off_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    hbyte_r    <= hbyte_nxt;
    hlast_r    <= hlast_nxt;
    kf_r       <= kf_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_dts_r  <= out_dts_nxt;
    out_kf_r   <= out_kf_nxt;
    if (pre_we) prefix_r[pos_r[1:0]] <= in_b;
  end

  // parameter set memories, one write and one registered read port each
  always_ff @(posedge clk) begin
    if (sps_we) sps_mem[cnt_in[SAW-1:0]] <= in_b;
    sps_rd_r <= sps_mem[sps_raddr];
  end

  always_ff @(posedge clk) begin
    if (pps_we) pps_mem[cnt_in[PAW-1:0]] <= in_b;
    pps_rd_r <= pps_mem[pps_raddr];
  end

endmodule

// ----- design/flvpk_checker.sv -----
// port level checks of the flv avc video tag packetizer and their bind
module flvpk_port_checks (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tlast,
  input logic        out_tuser
);

  logic        sof_r;
  logic        kf_r;
  logic [31:0] dts_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sof_r <= 1'b1;
      kf_r  <= 1'b0;
      dts_r <= 32'd0;
    end else if (out_tvalid && out_tready) begin
      sof_r <= out_tlast;
      kf_r  <= out_tuser;
      dts_r <= out_tdata[39:8];
    end
  end

  // nothing comes out right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output beat right after reset");

  // stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast)
      && $stable(out_tuser))
    else $error("stalled output beat changed");

  // a tag body opens with a valid flags byte
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && sof_r |-> (out_tdata[7:0] == flvpk_pkg::FLAGS_KEY)
      || (out_tdata[7:0] == flvpk_pkg::FLAGS_INTER && !out_tuser))
    else $error("bad flags byte at start of tag");

  // timestamp and keyframe flag stay put within a tag
  a_tag_const: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !sof_r |-> out_tuser == kf_r && out_tdata[39:8] == dts_r)
    else $error("tag side data changed within a tag");

endmodule

bind flv_avc_video_tag_packetizer flvpk_port_checks u_flvpk_port_checks (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
